// File: hdl/phcal_pkg.sv
// ============================================================================
// phcal_pkg
// Shared types and constants of the pH probe averaging calibrator.
// ============================================================================
`default_nettype none

package phcal_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int V_W        = 16;
    localparam int PH_W       = 16;
    localparam int STAT_W     = 2;
    localparam int CAL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Window sum holds up to 4095 * 256
    localparam int SUM_W = 20;

    // Work register: scaled average up to 4095 * 52800, divisor up to 16 bits
    localparam int DIV_W   = 28;
    localparam int DSR_W   = 16;
    localparam int DCNT_W  = 5;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Scaling constants
    localparam logic [DSR_W-1:0] FULL_SCALE_Q4 = 16'd52800;
    localparam logic [DSR_W-1:0] ADC_FULL      = 16'd4095;
    localparam int               PH_SEVEN_Q8   = 1792;
    localparam int               PH_SLOPE      = 768;

    // Constant division by reciprocal: floor(x / d) = (x * ceil(2^k / d)) >> k,
    // exact while k covers the dividend bits plus the divisor bits
    localparam int RECIP_W      = 29;
    localparam int AVG_SHIFT    = 28;
    localparam int VSCALE_SHIFT = 40;
    localparam logic [RECIP_W-1:0] VSCALE_RECIP =
        RECIP_W'(((64'd1 << VSCALE_SHIFT) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL));

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FAULT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DEGEN = 2'd2;

    // Calibration update codes
    localparam logic [CAL_W-1:0] CAL_NONE    = 2'd0;
    localparam logic [CAL_W-1:0] CAL_NEUTRAL = 2'd1;
    localparam logic [CAL_W-1:0] CAL_ACID    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH = 2'd1;

    // One finished or aborted window, front to back
    typedef struct packed {
        logic             fault;
        logic             capture;
        logic [SUM_W-1:0] sum;
    } t_job;

    // Neutral window bounds
    typedef struct packed {
        logic [V_W-1:0] win_low;
        logic [V_W-1:0] win_high;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/phcal_if.sv
// ============================================================================
// phcal_if
// Valid/ready channels: probe samples in, results out, configuration writes.
// ============================================================================
`default_nettype none

interface phcal_in_if;
    logic                         valid;
    logic                         ready;
    logic [phcal_pkg::ADC_W-1:0]  adc_sample;
    logic                         adc_fault;
    logic                         operation;

    modport source (output valid, adc_sample, adc_fault, operation, input ready);
    modport sink   (input valid, adc_sample, adc_fault, operation, output ready);
endinterface

interface phcal_out_if;
    logic                         valid;
    logic                         ready;
    logic [phcal_pkg::STAT_W-1:0] status;
    logic [phcal_pkg::V_W-1:0]    voltage_q4;
    logic signed [phcal_pkg::PH_W-1:0] ph_q8;
    logic [phcal_pkg::CAL_W-1:0]  cal_updated;

    modport source (output valid, status, voltage_q4, ph_q8, cal_updated, input ready);
    modport sink   (input valid, status, voltage_q4, ph_q8, cal_updated, output ready);
endinterface

interface phcal_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [phcal_pkg::CFG_IDX_W-1:0]  index;
    logic [phcal_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/phcal_front.sv
// ============================================================================
// phcal_front
// Sample accumulator: sums one window of samples and emits one job per
// finished or aborted window.
// ============================================================================
`default_nettype none

module phcal_front #(
    parameter int SAMPLES = 50
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    phcal_in_if.sink              i_in,
    input  wire logic             i_full,
    output logic                  o_push,
    output phcal_pkg::t_job       o_job
);

    localparam int CNT_W = $clog2(SAMPLES + 1);

    logic [phcal_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        w_take;
    logic [phcal_pkg::SUM_W-1:0] w_sum_inc;
    logic [CNT_W-1:0]            w_cnt_inc;
    logic                        w_last;

    // Accept while the job queue has room
    assign i_in.ready = !i_full;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_sum_inc  = r_sum + phcal_pkg::SUM_W'(i_in.adc_sample);
    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_last     = (w_cnt_inc == CNT_W'(SAMPLES));

    // Accumulate, close the window on its last sample, drop it on a fault
    always_comb begin
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        o_push        = 1'b0;
        o_job.fault   = i_in.adc_fault;
        o_job.capture = i_in.operation;
        o_job.sum     = w_sum_inc;
        if (w_take) begin
            if (i_in.adc_fault || w_last) begin
                n_sum  = '0;
                n_cnt  = '0;
                o_push = 1'b1;
            end else begin
                n_sum = w_sum_inc;
                n_cnt = w_cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: hdl/phcal_queue.sv
// ============================================================================
// phcal_queue
// Short job queue between the accumulator and the calibration engine.
// ============================================================================
`default_nettype none

module phcal_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  phcal_pkg::t_job       i_job,
    output logic                  o_full,
    input  wire logic             i_pop,
    output phcal_pkg::t_job       o_job,
    output logic                  o_empty
);

    phcal_pkg::t_job                r_mem [phcal_pkg::QUEUE_DEPTH];
    logic [phcal_pkg::QPTR_W-1:0]   r_wr;
    logic [phcal_pkg::QPTR_W-1:0]   r_rd;
    logic [phcal_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (phcal_pkg::QPTR_W + 1)'(phcal_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + phcal_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + phcal_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (phcal_pkg::QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (phcal_pkg::QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/phcal_back.sv
// ============================================================================
// phcal_back
// Calibration engine: averages a window sum, scales it to Q4 millivolts,
// computes pH by two-point calibration and applies calibration captures.
// The two constant divisions use reciprocal multiplication; the division by
// the calibration span runs on a bit-serial divider.
// ============================================================================
`default_nettype none

module phcal_back #(
    parameter int SAMPLES            = 50,
    parameter int NEUTRAL_DEFAULT_Q4 = 24000,
    parameter int ACID_DEFAULT_Q4    = 32519
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  phcal_pkg::t_job       i_job,
    output logic                  o_pop,
    input  phcal_pkg::t_cfg       i_cfg,
    phcal_out_if.source           o_out
);

    localparam int AVG_PROD_W = phcal_pkg::SUM_W + phcal_pkg::RECIP_W;
    localparam int VS_PROD_W  = phcal_pkg::DIV_W + phcal_pkg::RECIP_W;
    localparam logic [phcal_pkg::RECIP_W-1:0] AVG_RECIP = phcal_pkg::RECIP_W'(
        ((64'd1 << phcal_pkg::AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MUL,
        S_VDIV,
        S_PHS,
        S_PHDIV,
        S_FIN
    } t_state;

    t_state                          r_state;
    logic [phcal_pkg::DSR_W:0]       r_rem;
    logic [phcal_pkg::DIV_W-1:0]     r_quo;
    logic [phcal_pkg::DSR_W-1:0]     r_div;
    logic [phcal_pkg::DCNT_W-1:0]    r_cnt;
    logic [phcal_pkg::V_W-1:0]       r_v;
    logic                            r_neg;
    logic                            r_degen;
    logic                            r_fault;
    logic                            r_capture;
    logic [phcal_pkg::V_W-1:0]       r_neutral;
    logic [phcal_pkg::V_W-1:0]       r_acid;
    logic                            r_ovalid;
    logic [phcal_pkg::STAT_W-1:0]    r_status;
    logic [phcal_pkg::V_W-1:0]       r_voltage;
    logic signed [phcal_pkg::PH_W-1:0] r_ph;
    logic [phcal_pkg::CAL_W-1:0]     r_cal;

    logic [phcal_pkg::DSR_W:0]       w_shift;
    logic                            w_ge;
    logic [phcal_pkg::DSR_W:0]       w_rem_step;
    logic [phcal_pkg::DIV_W-1:0]     w_quo_step;
    logic [AVG_PROD_W-1:0]           w_avg_prod;
    logic [VS_PROD_W-1:0]            w_vs_prod;
    logic signed [phcal_pkg::V_W:0]  w_dv;
    logic signed [phcal_pkg::V_W:0]  w_da;
    logic [phcal_pkg::V_W:0]         w_dv_abs;
    logic [phcal_pkg::V_W:0]         w_da_abs;
    logic [phcal_pkg::DIV_W-1:0]     w_num;
    logic signed [phcal_pkg::DIV_W+1:0] w_q;
    logic signed [phcal_pkg::DIV_W+1:0] w_ph_full;
    logic signed [phcal_pkg::PH_W-1:0]  w_ph_sat;
    logic                            w_in_window;
    logic                            w_out_free;
    logic                            w_div_last;

    // One restoring division step per cycle
    assign w_shift    = {r_rem[phcal_pkg::DSR_W-1:0], r_quo[phcal_pkg::DIV_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_rem_step = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
    assign w_quo_step = {r_quo[phcal_pkg::DIV_W-2:0], w_ge};
    assign w_div_last = (r_cnt == '0);

    // Average and scale by reciprocal multiplication
    assign w_avg_prod = AVG_PROD_W'(r_quo[phcal_pkg::SUM_W-1:0]) * AVG_PROD_W'(AVG_RECIP);
    assign w_vs_prod  = VS_PROD_W'(r_quo) * VS_PROD_W'(phcal_pkg::VSCALE_RECIP);

    // Signed distances from the neutral point
    assign w_dv     = $signed({1'b0, r_v}) - $signed({1'b0, r_neutral});
    assign w_da     = $signed({1'b0, r_acid}) - $signed({1'b0, r_neutral});
    assign w_dv_abs = w_dv[phcal_pkg::V_W] ? 17'(-w_dv) : 17'(w_dv);
    assign w_da_abs = w_da[phcal_pkg::V_W] ? 17'(-w_da) : 17'(w_da);
    assign w_num    = phcal_pkg::DIV_W'(w_dv_abs) * phcal_pkg::DIV_W'(phcal_pkg::PH_SLOPE);

    // Apply the quotient sign, offset by pH 7 and saturate
    assign w_q       = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign w_ph_full = 30'(phcal_pkg::PH_SEVEN_Q8) - w_q;
    always_comb begin
        if (w_ph_full > 30'sd32767) begin
            w_ph_sat = 16'sh7FFF;
        end else if (w_ph_full < -30'sd32768) begin
            w_ph_sat = -16'sh8000;
        end else begin
            w_ph_sat = w_ph_full[phcal_pkg::PH_W-1:0];
        end
    end

    assign w_in_window = (r_v > i_cfg.win_low) && (r_v < i_cfg.win_high);
    assign w_out_free  = !r_ovalid || o_out.ready;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_status;
    assign o_out.voltage_q4  = r_voltage;
    assign o_out.ph_q8       = r_ph;
    assign o_out.cal_updated = r_cal;

    // Sequence one window through average, scale, pH and capture; a fault job goes straight to issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_neutral <= phcal_pkg::V_W'(NEUTRAL_DEFAULT_Q4);
            r_acid    <= phcal_pkg::V_W'(ACID_DEFAULT_Q4);
        end else begin
            // Retire the taken result unless a new one is issued this cycle
            if (r_ovalid && o_out.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_fault   <= i_job.fault;
                        r_capture <= i_job.capture;
                        r_degen   <= 1'b0;
                        r_quo     <= phcal_pkg::DIV_W'(i_job.sum);
                        r_state   <= i_job.fault ? S_FIN : S_AVG;
                    end
                end
                S_AVG: begin
                    r_quo   <= phcal_pkg::DIV_W'(
                                   w_avg_prod[phcal_pkg::AVG_SHIFT +: phcal_pkg::ADC_W]);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_quo   <= phcal_pkg::DIV_W'(r_quo[phcal_pkg::ADC_W-1:0])
                               * phcal_pkg::DIV_W'(phcal_pkg::FULL_SCALE_Q4);
                    r_state <= S_VDIV;
                end
                S_VDIV: begin
                    r_v     <= w_vs_prod[phcal_pkg::VSCALE_SHIFT +: phcal_pkg::V_W];
                    r_state <= S_PHS;
                end
                S_PHS: begin
                    if (w_da == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_quo   <= w_num;
                        r_rem   <= '0;
                        r_div   <= w_da_abs[phcal_pkg::DSR_W-1:0];
                        r_neg   <= w_dv[phcal_pkg::V_W] ^ w_da[phcal_pkg::V_W];
                        r_cnt   <= phcal_pkg::DCNT_W'(phcal_pkg::DIV_W - 1);
                        r_state <= S_PHDIV;
                    end
                end
                S_PHDIV: begin
                    r_rem <= w_rem_step;
                    r_quo <= w_quo_step;
                    r_cnt <= r_cnt - phcal_pkg::DCNT_W'(1);
                    if (w_div_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold the result until the output register is free
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_fault) begin
                            r_status  <= phcal_pkg::STATUS_FAULT;
                            r_voltage <= '0;
                            r_ph      <= '0;
                            r_cal     <= phcal_pkg::CAL_NONE;
                        end else begin
                            r_status  <= r_degen ? phcal_pkg::STATUS_DEGEN
                                                 : phcal_pkg::STATUS_OK;
                            r_voltage <= r_v;
                            r_ph      <= r_degen ? '0 : w_ph_sat;
                            if (!r_capture) begin
                                r_cal <= phcal_pkg::CAL_NONE;
                            end else if (w_in_window) begin
                                r_cal     <= phcal_pkg::CAL_NEUTRAL;
                                r_neutral <= r_v;
                            end else begin
                                r_cal  <= phcal_pkg::CAL_ACID;
                                r_acid <= r_v;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // Calibration points move only when a result is issued
    a_points_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_FIN && w_out_free) |=> $stable(r_neutral) && $stable(r_acid))
        else $error("calibration point changed outside result issue");

    // A converter fault result carries no measurement
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status == phcal_pkg::STATUS_FAULT) |->
        (r_voltage == '0 && r_ph == '0 && r_cal == phcal_pkg::CAL_NONE))
        else $error("fault result with nonzero payload");

    // Equal calibration points give a zero pH
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status == phcal_pkg::STATUS_DEGEN) |-> (r_ph == '0))
        else $error("degenerate result with nonzero pH");

    // Taking a job moves the engine out of idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("engine stayed idle after taking a job");
`endif

endmodule

`default_nettype wire

// File: hdl/ph_probe_averaging_calibrator_core.sv
// ============================================================================
// ph_probe_averaging_calibrator_core
// pH probe averaging calibrator: window averaging, Q4 mV scaling, two-point
// pH calibration with neutral/acid capture.
// ============================================================================
// i_in  : one 12-bit probe sample per item, with fault and capture flags.
// o_out : one result per finished window (SAMPLES samples) or per fault.
// i_cfg : neutral window bounds (index 0 low, 1 high); always ready, write
//         only while no window is in flight.
// Throughput: one sample per cycle while the 4-deep job queue has room.
//   The engine works on one job at a time, so windows that close faster than
//   the engine finishes a job, or runs of faults, fill the queue and stall i_in.
// Flow: each job is written into the queue; the engine takes it once idle
//   and steps through average, scale and pH setup, the one-bit-per-cycle
//   pH division and the issue to the output register. Equal points skip
//   the division; a fault goes straight to issue.
// Reset: sum, count and queue clear; points and bounds load their defaults.
// Stall: a result waits in the output register; the engine holds the next
//   one until it is taken, then the queue and finally the input fill up.
// ============================================================================
`default_nettype none

module ph_probe_averaging_calibrator_core #(
    parameter int SAMPLES            = 50,
    parameter int NEUTRAL_DEFAULT_Q4 = 24000,
    parameter int ACID_DEFAULT_Q4    = 32519
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    phcal_in_if.sink    i_in,
    phcal_out_if.source o_out,
    phcal_cfg_if.sink   i_cfg
);

    phcal_pkg::t_cfg r_cfg;
    phcal_pkg::t_job w_push_job;
    phcal_pkg::t_job w_pop_job;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_low  <= 16'd20800;
            r_cfg.win_high <= 16'd27200;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                phcal_pkg::REG_WIN_LOW:  r_cfg.win_low  <= i_cfg.data;
                phcal_pkg::REG_WIN_HIGH: r_cfg.win_high <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    phcal_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    phcal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    phcal_back #(
        .SAMPLES            (SAMPLES),
        .NEUTRAL_DEFAULT_Q4 (NEUTRAL_DEFAULT_Q4),
        .ACID_DEFAULT_Q4    (ACID_DEFAULT_Q4)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking regression of the pH probe averaging calibrator. Sample
// windows go in over the valid/ready input channel, and a cycle-free
// predictor works out the reading that each finished or aborted window gives.
// The stimulus is a directed table of windows and register writes, then
// random phases under several window bound settings. Both channel sides
// idle at random.
// ============================================================================
module testbench;

    localparam int SAMPLES            = 50;
    localparam int NEUTRAL_DEFAULT_Q4 = 24000;
    localparam int ACID_DEFAULT_Q4    = 32519;
    localparam int RESET_CYCLES       = 4;
    localparam int DRAIN_CYCLES       = 120;
    localparam int CYCLE_LIMIT        = 1000000;
    localparam int RANDOM_PHASES      = 6;
    localparam int PHASE_ITEMS        = 60;
    localparam int PHASE_READINGS     = 2;
    localparam int ADC_MAX            = 4095;
    localparam int Q4_MAX             = 52800;

    // Register indexes that the block has no register behind
    localparam logic [phcal_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [phcal_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [phcal_pkg::STAT_W-1:0]      status;
        logic [phcal_pkg::V_W-1:0]         voltage_q4;
        logic signed [phcal_pkg::PH_W-1:0] ph_q8;
        logic [phcal_pkg::CAL_W-1:0]       cal_updated;
    } t_reading;

    localparam t_reading FAULT_READING = '{
        status: phcal_pkg::STATUS_FAULT, voltage_q4: '0, ph_q8: '0,
        cal_updated: phcal_pkg::CAL_NONE};

    typedef enum logic [1:0] {STEP_WINDOW, STEP_CFG} t_step_kind;
    typedef enum logic [1:0] {SHAPE_FLAT, SHAPE_ALT, SHAPE_JITTER, SHAPE_NOISE} t_shape;

    typedef struct {
        t_step_kind                       kind;
        t_shape                           shape;
        int                               level;
        int                               fault_at;
        bit                               capture;
        bit                               typed;
        t_reading                         expected;
        logic [phcal_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [phcal_pkg::CFG_DATA_W-1:0] reg_data;
    } t_step;

    logic clk;
    logic rst_n;

    phcal_in_if  in_ch ();
    phcal_out_if out_ch ();
    phcal_cfg_if cfg_ch ();

    ph_probe_averaging_calibrator_core #(
        .SAMPLES            (SAMPLES),
        .NEUTRAL_DEFAULT_Q4 (NEUTRAL_DEFAULT_Q4),
        .ACID_DEFAULT_Q4    (ACID_DEFAULT_Q4)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: window accumulator, calibration points, window bounds
    int unsigned               acc_sum;
    int unsigned               acc_count;
    logic [phcal_pkg::V_W-1:0] neutral_pt;
    logic [phcal_pkg::V_W-1:0] acid_pt;
    logic [phcal_pkg::V_W-1:0] win_low;
    logic [phcal_pkg::V_W-1:0] win_high;

    t_reading pending_readings[$];
    int       capture_levels[$];
    t_step    directed[$];

    int errors          = 0;
    int items_sent      = 0;
    int readings_due    = 0;
    int readings_seen   = 0;
    int windows_done    = 0;
    int faults_seen     = 0;
    int captures_done   = 0;
    int degen_seen      = 0;
    int sat_seen        = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;
    bit src_burst       = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ph_probe_averaging_calibrator_core regression: fail");
            $finish;
        end
    end

    // Work out the reading for one accepted item; return 1 when one is due
    function automatic bit predict_sample(input logic [phcal_pkg::ADC_W-1:0] raw,
                                          input bit fault, input bit capture,
                                          output t_reading rd);
        longint avg, volts, q, ph;
        rd = '0;
        if (fault) begin
            acc_sum   = 0;
            acc_count = 0;
            rd.status = phcal_pkg::STATUS_FAULT;
            faults_seen++;
            return 1'b1;
        end
        acc_sum   += raw;
        acc_count += 1;
        if (acc_count < SAMPLES) return 1'b0;

        avg       = acc_sum / SAMPLES;
        acc_sum   = 0;
        acc_count = 0;
        volts     = (avg * longint'(phcal_pkg::FULL_SCALE_Q4)) / longint'(phcal_pkg::ADC_FULL);
        windows_done++;
        rd.voltage_q4 = volts[phcal_pkg::V_W-1:0];

        // Two-point line through the points held before any capture
        if (acid_pt == neutral_pt) begin
            rd.status = phcal_pkg::STATUS_DEGEN;
            degen_seen++;
        end else begin
            q  = (longint'(phcal_pkg::PH_SLOPE) * (volts - longint'(neutral_pt)))
                 / (longint'(acid_pt) - longint'(neutral_pt));
            ph = longint'(phcal_pkg::PH_SEVEN_Q8) - q;
            if (ph > 32767 || ph < -32768) sat_seen++;
            if (ph > 32767) ph = 32767;
            if (ph < -32768) ph = -32768;
            rd.status = phcal_pkg::STATUS_OK;
            rd.ph_q8  = ph[phcal_pkg::PH_W-1:0];
        end

        // Store the capture as neutral only strictly inside the bounds
        rd.cal_updated = phcal_pkg::CAL_NONE;
        if (capture) begin
            captures_done++;
            if (volts > longint'(win_low) && volts < longint'(win_high)) begin
                neutral_pt     = volts[phcal_pkg::V_W-1:0];
                rd.cal_updated = phcal_pkg::CAL_NEUTRAL;
            end else begin
                acid_pt        = volts[phcal_pkg::V_W-1:0];
                rd.cal_updated = phcal_pkg::CAL_ACID;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [phcal_pkg::ADC_W-1:0] clamp_level(input int x);
        if (x < 0) return '0;
        if (x > ADC_MAX) return phcal_pkg::ADC_W'(ADC_MAX);
        return x[phcal_pkg::ADC_W-1:0];
    endfunction

    function automatic logic [phcal_pkg::ADC_W-1:0] sample_for(input t_shape shape,
                                                              input int level,
                                                              input int idx);
        case (shape)
            SHAPE_FLAT:   return level[phcal_pkg::ADC_W-1:0];
            SHAPE_ALT:    return (idx % 2) ? phcal_pkg::ADC_W'(ADC_MAX) : '0;
            SHAPE_JITTER: return clamp_level(level + int'($urandom_range(0, 40)) - 20);
            default:      return phcal_pkg::ADC_W'($urandom_range(0, ADC_MAX));
        endcase
    endfunction

    function automatic int voltage_of(input int level);
        return level * Q4_MAX / ADC_MAX;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_burst || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Favor levels near the bounds and repeats of earlier captures
    function automatic int pick_level();
        int r;
        int bnd;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, ADC_MAX);
        if (r < 70) begin
            bnd = $urandom_range(0, 1) ? int'(win_low) : int'(win_high);
            return clamp_level(bnd * ADC_MAX / Q4_MAX + int'($urandom_range(0, 6)) - 3);
        end
        if (r < 85 && capture_levels.size() != 0)
            return capture_levels[$urandom_range(0, capture_levels.size() - 1)];
        return $urandom_range(0, 1) ? ADC_MAX : 0;
    endfunction

    function automatic t_step win_step(input t_shape shape, input int level, input int fault_at,
                                       input bit capture, input bit typed,
                                       input t_reading expected);
        t_step st;
        st.kind      = STEP_WINDOW;
        st.shape     = shape;
        st.level     = level;
        st.fault_at  = fault_at;
        st.capture   = capture;
        st.typed     = typed;
        st.expected  = expected;
        st.reg_index = phcal_pkg::REG_WIN_LOW;
        st.reg_data  = '0;
        return st;
    endfunction

    function automatic t_step cfg_step(input logic [phcal_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [phcal_pkg::CFG_DATA_W-1:0] data);
        t_step st;
        st           = win_step(SHAPE_FLAT, 0, -1, 1'b0, 1'b0, '0);
        st.kind      = STEP_CFG;
        st.reg_index = idx;
        st.reg_data  = data;
        return st;
    endfunction

    // Drive one item, wait for the handshake, then predict its reading
    task automatic send_item(input logic [phcal_pkg::ADC_W-1:0] raw, input bit fault,
                             input bit op, input bit typed, input t_reading typed_rd);
        int gap;
        t_reading rd;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.adc_sample <= raw;
        in_ch.adc_fault  <= fault;
        in_ch.operation  <= op;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
        if (predict_sample(raw, fault, op, rd)) begin
            pending_readings.push_back(typed ? typed_rd : rd);
            readings_due++;
        end
    endtask

    // One window; a fault at fault_at ends it early
    task automatic run_window(input t_shape shape, input int level, input int fault_at,
                              input bit capture, input bit typed, input t_reading typed_rd);
        for (int i = 0; i < SAMPLES; i++) begin
            if (i == fault_at) begin
                send_item(sample_for(shape, level, i), 1'b1, capture, typed, typed_rd);
                break;
            end
            send_item(sample_for(shape, level, i), 1'b0,
                      (i == SAMPLES - 1) ? capture : 1'($urandom_range(0, 1)),
                      typed && (i == SAMPLES - 1), typed_rd);
        end
    endtask

    // Write a register once the block has drained
    task automatic write_reg(input logic [phcal_pkg::CFG_IDX_W-1:0] idx,
                             input logic [phcal_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        reg_writes++;
        case (idx)
            phcal_pkg::REG_WIN_LOW:  win_low  = data;
            phcal_pkg::REG_WIN_HIGH: win_high = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random window: mostly well formed, some fault-aborted, some pure noise
    task automatic random_window();
        int r, s, lvl, fpos;
        t_shape shape;
        bit cap;
        r   = $urandom_range(0, 99);
        s   = $urandom_range(0, 99);
        lvl = pick_level();
        src_burst = ($urandom_range(0, 9) == 0);
        if (s < 50) shape = SHAPE_FLAT;
        else if (s < 80) shape = SHAPE_JITTER;
        else if (s < 93) shape = SHAPE_NOISE;
        else shape = SHAPE_ALT;

        if (r < 13) begin
            do send_item(phcal_pkg::ADC_W'($urandom_range(0, ADC_MAX)),
                         ($urandom_range(0, 24) == 0), 1'($urandom_range(0, 1)), 1'b0, '0);
            while (acc_count != 0);
        end else begin
            fpos = (r < 25) ? int'($urandom_range(0, SAMPLES - 1)) : -1;
            cap  = ($urandom_range(0, 99) < 35);
            run_window(shape, lvl, fpos, cap, 1'b0, '0);
            if (cap && fpos < 0) begin
                capture_levels.push_back(lvl);
                if (capture_levels.size() > 8) void'(capture_levels.pop_front());
            end
        end
    endtask

    // Output side: runs of ready with stalls in between
    initial begin
        int run, stall, r;
        out_ch.ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            @(negedge clk);
            out_ch.ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 50) stall = 1;
            else if (r < 85) stall = $urandom_range(2, 4);
            else if (r < 97) stall = $urandom_range(5, 12);
            else stall = $urandom_range(20, 40);
            @(negedge clk);
            out_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clk);
        end
    end

    // Compare each reading with the oldest one due
    always @(posedge clk) begin : check_readings
        t_reading want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected reading: status %0d voltage_q4 %0d ph_q8 %0d cal_updated %0d",
                       out_ch.status, out_ch.voltage_q4, out_ch.ph_q8, out_ch.cal_updated);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    errors++;
                end
                if (out_ch.voltage_q4 !== want.voltage_q4) begin
                    $error("voltage_q4: expected %0d, got %0d", want.voltage_q4,
                           out_ch.voltage_q4);
                    errors++;
                end
                if (out_ch.ph_q8 !== want.ph_q8) begin
                    $error("ph_q8: expected %0d, got %0d", want.ph_q8, out_ch.ph_q8);
                    errors++;
                end
                if (out_ch.cal_updated !== want.cal_updated) begin
                    $error("cal_updated: expected %0d, got %0d", want.cal_updated,
                           out_ch.cal_updated);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int lo, hi, a, b, start_items, start_due;
        in_ch.valid      = 1'b0;
        in_ch.adc_sample = '0;
        in_ch.adc_fault  = 1'b0;
        in_ch.operation  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = phcal_pkg::REG_WIN_LOW;
        cfg_ch.data      = '0;
        rst_n            = 1'b0;

        // Predictor reset state
        acc_sum    = 0;
        acc_count  = 0;
        neutral_pt = phcal_pkg::V_W'(NEUTRAL_DEFAULT_Q4);
        acid_pt    = phcal_pkg::V_W'(ACID_DEFAULT_Q4);
        win_low    = 16'd20800;
        win_high   = 16'd27200;

        // Directed table: faults, extremes, captures, saturation, equal points
        directed.push_back(win_step(SHAPE_FLAT,   0,    0, 1'b0, 1'b1, FAULT_READING));
        directed.push_back(win_step(SHAPE_FLAT,   0,   -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   4095, -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_ALT,    0,   -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   1000, 49, 1'b0, 1'b1, FAULT_READING));
        directed.push_back(win_step(SHAPE_FLAT,   2000, 25, 1'b1, 1'b1, FAULT_READING));
        directed.push_back(win_step(SHAPE_FLAT,   1861, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   2523, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_NOISE,  0,   -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   2109, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   2110, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   0,   -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   4095, -1, 1'b0, 1'b0, '0));
        directed.push_back(cfg_step(REG_SPARE_2, 16'hFFFF));
        directed.push_back(cfg_step(phcal_pkg::REG_WIN_LOW, 16'(Q4_MAX)));
        directed.push_back(cfg_step(phcal_pkg::REG_WIN_HIGH, 16'd0));
        directed.push_back(cfg_step(REG_SPARE_3, 16'd0));
        directed.push_back(win_step(SHAPE_FLAT,   2109, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   3000, -1, 1'b0, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   1500, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_JITTER, 1500, -1, 1'b0, 1'b0, '0));
        directed.push_back(cfg_step(phcal_pkg::REG_WIN_LOW, 16'd0));
        directed.push_back(cfg_step(phcal_pkg::REG_WIN_HIGH, 16'(Q4_MAX)));
        directed.push_back(win_step(SHAPE_FLAT,   4095, -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   0,   -1, 1'b1, 1'b0, '0));
        directed.push_back(win_step(SHAPE_FLAT,   2000, -1, 1'b1, 1'b0, '0));

        // Hold reset, release on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed[k]) begin
            if (directed[k].kind == STEP_CFG)
                write_reg(directed[k].reg_index, directed[k].reg_data);
            else
                run_window(directed[k].shape, directed[k].level, directed[k].fault_at,
                           directed[k].capture, directed[k].typed, directed[k].expected);
        end

        // Random phases, each under its own window bounds
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            a = voltage_of($urandom_range(0, ADC_MAX));
            b = voltage_of($urandom_range(0, ADC_MAX));
            case (p)
                0: begin lo = 20800; hi = 27200; end
                1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
                2: begin lo = 0; hi = Q4_MAX; end
                3: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
                4: begin lo = a; hi = a; end
                default: begin
                    lo = $urandom_range(0, Q4_MAX);
                    hi = $urandom_range(0, Q4_MAX);
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(phcal_pkg::REG_WIN_LOW, lo[phcal_pkg::CFG_DATA_W-1:0]);
                write_reg(phcal_pkg::REG_WIN_HIGH, hi[phcal_pkg::CFG_DATA_W-1:0]);
            end else begin
                write_reg(phcal_pkg::REG_WIN_HIGH, hi[phcal_pkg::CFG_DATA_W-1:0]);
                write_reg(phcal_pkg::REG_WIN_LOW, lo[phcal_pkg::CFG_DATA_W-1:0]);
            end
            start_items = items_sent;
            start_due   = readings_due;
            while (items_sent - start_items < PHASE_ITEMS ||
                   readings_due - start_due < PHASE_READINGS)
                random_window();
        end

        // Drain and settle
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items, %0d readings checked (%0d windows, %0d faults, %0d captures)",
                 items_sent, readings_seen, windows_done, faults_seen, captures_done);
        $display("run: %0d equal-point readings, %0d saturated pH, %0d register writes",
                 degen_seen, sat_seen, reg_writes);
        if (errors == 0)
            $display("ph_probe_averaging_calibrator_core regression: pass");
        else
            $display("ph_probe_averaging_calibrator_core regression: fail");
        $finish;
    end

endmodule
